// File: rtl/core/lss_pkg.sv
// Shared types and constants for the 3x3 Laplacian sharpening stream.
// No dependencies; every other file in rtl/core refers to it by scoped names.
package lss_pkg;

   localparam int SAMPLE_W    = 8;
   localparam int ROW_W       = 16;
   localparam int CH_W        = 3;
   localparam int CFG_WIDTH_W = 11;
   localparam int PADDR_W     = 4;
   localparam int PDATA_W     = 32;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = 2;
   localparam int QCNT_W      = 3;

   typedef logic [SAMPLE_W-1:0] sample_type;
   typedef logic [1:0]          reg_idx_type;

   localparam reg_idx_type REG_IMAGE_WIDTH   = 2'd0;
   localparam reg_idx_type REG_IMAGE_HEIGHT  = 2'd1;
   localparam reg_idx_type REG_CHANNEL_COUNT = 2'd2;

   localparam logic [CFG_WIDTH_W-1:0] RESET_IMAGE_WIDTH   = 11'd640;
   localparam logic [ROW_W-1:0]       RESET_IMAGE_HEIGHT  = 16'd480;
   localparam logic [CH_W-1:0]        RESET_CHANNEL_COUNT = 3'd1;

   // One classified word: the five taps of a sample plus its position flags.
   typedef struct packed {
      sample_type centre;
      sample_type above;
      sample_type below;
      sample_type left_nb;
      sample_type right_nb;
      logic       interior;
      logic       last_row;
      logic       last_col;
   } entry_type;

endpackage

// File: rtl/core/lss_stream_if.sv
// Valid/ready channel interfaces for the sample input and the result output.
// Depends on lss_pkg for the sample type.
interface lss_req_if;
   logic               valid;
   logic               ready;
   lss_pkg::sample_type sample_in;

   modport source (output valid, output sample_in, input ready);
   modport sink   (input valid, input sample_in, output ready);
endinterface

interface lss_rsp_if;
   logic               valid;
   logic               ready;
   lss_pkg::sample_type sample_out;
   logic               frame_last;

   modport source (output valid, output sample_out, output frame_last, input ready);
   modport sink   (input valid, input sample_out, input frame_last, output ready);
endinterface

// File: rtl/core/laplacian_sharpen_3x3_stream.sv
// Path: the sample that completes a result word passes the read stage, the word queue
// and the output register; output runs one row behind the input, so row 0 gives no words.
// Throughput: one sample per clock while rsp_stream is ready; on the last row each sample gives two words,
// so there the single output register takes a new sample only once both its words are sent.
// Reset (synchronous, active high) clears position, queue and valids, and loads the
// default geometry; line stores are not cleared and need no clearing pass.
module laplacian_sharpen_3x3_stream #(
   parameter int MAX_WIDTH    = 1024,
   parameter int MAX_CHANNELS = 4
) (
   input  logic                          clock,
   input  logic                          reset,
   lss_req_if.sink                       req_stream,
   lss_rsp_if.source                     rsp_stream,
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [lss_pkg::PADDR_W-1:0]   csr_paddr,
   input  logic [lss_pkg::PDATA_W-1:0]   csr_pwdata,
   output logic [lss_pkg::PDATA_W-1:0]   csr_prdata,
   output logic                          csr_pready
);

   localparam int DEPTH = MAX_WIDTH * MAX_CHANNELS;
   localparam int LEN_W = $clog2(DEPTH + 1);
   localparam int WID_W = $clog2(MAX_WIDTH + 1);

   logic [lss_pkg::CFG_WIDTH_W-1:0] width_ff, width_in;
   logic [lss_pkg::ROW_W-1:0]       height_ff, height_in;
   logic [lss_pkg::CH_W-1:0]        chan_ff, chan_in;

   lss_pkg::reg_idx_type            reg_idx;
   logic                            cfg_write, cfg_clear;

   logic [WID_W-1:0]                w_eff;
   logic [lss_pkg::CH_W-1:0]        ch_eff;
   logic [lss_pkg::ROW_W-1:0]       h_eff;
   logic [LEN_W-1:0]                len, len_lo;

   logic                            q_push, q_full, q_pop, q_valid;
   lss_pkg::entry_type              q_push_entry, q_pop_entry;

   assign csr_pready = 1'b1;
   assign reg_idx    = csr_paddr[3:2];
   assign cfg_write  = csr_psel && csr_penable && csr_pwrite;
   assign cfg_clear  = cfg_write && (reg_idx inside {lss_pkg::REG_IMAGE_WIDTH,
                                                     lss_pkg::REG_IMAGE_HEIGHT,
                                                     lss_pkg::REG_CHANNEL_COUNT});

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      chan_in   = chan_ff;
      if (cfg_write) begin
         case (reg_idx)
            lss_pkg::REG_IMAGE_WIDTH:   width_in  = csr_pwdata[lss_pkg::CFG_WIDTH_W-1:0];
            lss_pkg::REG_IMAGE_HEIGHT:  height_in = csr_pwdata[lss_pkg::ROW_W-1:0];
            lss_pkg::REG_CHANNEL_COUNT: chan_in   = csr_pwdata[lss_pkg::CH_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= lss_pkg::RESET_IMAGE_WIDTH;
         height_ff <= lss_pkg::RESET_IMAGE_HEIGHT;
         chan_ff   <= lss_pkg::RESET_CHANNEL_COUNT;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
         chan_ff   <= chan_in;
      end
   end

   always_comb begin
      case (reg_idx)
         lss_pkg::REG_IMAGE_WIDTH:   csr_prdata = lss_pkg::PDATA_W'(width_ff);
         lss_pkg::REG_IMAGE_HEIGHT:  csr_prdata = lss_pkg::PDATA_W'(height_ff);
         lss_pkg::REG_CHANNEL_COUNT: csr_prdata = lss_pkg::PDATA_W'(chan_ff);
         default:                    csr_prdata = '0;
      endcase
   end

   // bring the geometry into range
   always_comb begin
      if (int'(width_ff) > MAX_WIDTH) begin
         w_eff = WID_W'(MAX_WIDTH);
      end else if (width_ff < lss_pkg::CFG_WIDTH_W'(3)) begin
         w_eff = WID_W'(3);
      end else begin
         w_eff = WID_W'(width_ff);
      end

      if (chan_ff == '0) begin
         ch_eff = lss_pkg::CH_W'(1);
      end else if (int'(chan_ff) > MAX_CHANNELS) begin
         ch_eff = lss_pkg::CH_W'(MAX_CHANNELS);
      end else begin
         ch_eff = chan_ff;
      end

      h_eff  = (height_ff < lss_pkg::ROW_W'(3)) ? lss_pkg::ROW_W'(3) : height_ff;
      len    = LEN_W'(w_eff) * LEN_W'(ch_eff);
      len_lo = len - LEN_W'(ch_eff);
   end

   lss_front #(
      .MAX_WIDTH    (MAX_WIDTH),
      .MAX_CHANNELS (MAX_CHANNELS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_stream (req_stream),
      .cfg_len    (len),
      .cfg_len_lo (len_lo),
      .cfg_ch     (ch_eff),
      .cfg_height (h_eff),
      .cfg_clear  (cfg_clear),
      .q_push     (q_push),
      .q_entry    (q_push_entry),
      .q_full     (q_full)
   );

   lss_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (q_push_entry),
      .full       (q_full),
      .pop        (q_pop),
      .pop_entry  (q_pop_entry),
      .not_empty  (q_valid)
   );

   lss_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (q_valid),
      .q_entry    (q_pop_entry),
      .q_pop      (q_pop),
      .rsp_stream (rsp_stream)
   );

endmodule

// File: rtl/core/lss_front.sv
// Front end: accepts samples, tracks frame position, runs both line stores
// and the left-neighbour window, and pushes classified words. Uses lss_pkg.
module lss_front #(
   parameter int MAX_WIDTH    = 1024,
   parameter int MAX_CHANNELS = 4
) (
   input  logic                         clock,
   input  logic                         reset,
   lss_req_if.sink                      req_stream,
   input  logic [$clog2(MAX_WIDTH*MAX_CHANNELS+1)-1:0] cfg_len,
   input  logic [$clog2(MAX_WIDTH*MAX_CHANNELS+1)-1:0] cfg_len_lo,
   input  logic [lss_pkg::CH_W-1:0]     cfg_ch,
   input  logic [lss_pkg::ROW_W-1:0]    cfg_height,
   input  logic                         cfg_clear,
   output logic                         q_push,
   output lss_pkg::entry_type           q_entry,
   input  logic                         q_full
);

   localparam int DEPTH     = MAX_WIDTH * MAX_CHANNELS;
   localparam int ADDR_W    = $clog2(DEPTH);
   localparam int LEN_W     = $clog2(DEPTH + 1);
   localparam int WIN_IDX_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

   // position
   logic [ADDR_W-1:0]           col_ff, col_in;
   logic [lss_pkg::ROW_W-1:0]   row_ff, row_in;
   logic [LEN_W-1:0]            col_ext;
   logic [lss_pkg::ROW_W:0]     row_next;
   logic [ADDR_W-1:0]           east_addr;
   logic                        accept, advance;
   logic                        last_col, last_row, has_res, interior;

   // line stores and their read registers
   lss_pkg::sample_type         older_row_ff  [DEPTH];
   lss_pkg::sample_type         middle_row_ff [DEPTH];
   lss_pkg::sample_type         mid_rd_ff, old_rd_ff, east_rd_ff;

   // stage after the store read
   logic                        s1_valid_ff, s1_valid_in;
   logic [ADDR_W-1:0]           s1_col_ff;
   lss_pkg::sample_type         s1_now_ff;
   logic                        s1_has_res_ff, s1_interior_ff;
   logic                        s1_last_row_ff, s1_last_col_ff;

   lss_pkg::sample_type         win_ff [MAX_CHANNELS];

   assign accept   = req_stream.valid && req_stream.ready;
   assign col_ext  = LEN_W'(col_ff);
   assign row_next = {1'b0, row_ff} + (lss_pkg::ROW_W + 1)'(1);
   assign last_col = (col_ext + LEN_W'(1)) >= cfg_len;
   assign last_row = row_next >= {1'b0, cfg_height};
   assign has_res  = row_ff != '0;
   assign interior = (row_ff >= lss_pkg::ROW_W'(2)) && (col_ext >= LEN_W'(cfg_ch))
                     && (col_ext < cfg_len_lo);
   // past the row end the east tap is not used, so let the address wrap
   assign east_addr = col_ff + ADDR_W'(cfg_ch);

   assign advance          = s1_valid_ff && (!s1_has_res_ff || !q_full);
   assign q_push           = s1_valid_ff && s1_has_res_ff && !q_full;
   assign req_stream.ready = !s1_valid_ff || advance;

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (cfg_clear) begin
         col_in = '0;
         row_in = '0;
      end else if (accept) begin
         if (last_col) begin
            col_in = '0;
            row_in = last_row ? '0 : row_next[lss_pkg::ROW_W-1:0];
         end else begin
            col_in = col_ff + ADDR_W'(1);
         end
      end
   end

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (advance) begin
         s1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff      <= '0;
         row_ff      <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         col_ff      <= col_in;
         row_ff      <= row_in;
         s1_valid_ff <= s1_valid_in;
      end
   end

   // middle row: read-first, so column c still answers the previous row
   always_ff @(posedge clock) begin
      if (accept) begin
         mid_rd_ff             <= middle_row_ff[col_ff];
         east_rd_ff            <= middle_row_ff[east_addr];
         middle_row_ff[col_ff] <= req_stream.sample_in;
      end
   end

   // older row: take the middle sample once it has been read out
   always_ff @(posedge clock) begin
      if (accept) begin
         old_rd_ff <= older_row_ff[col_ff];
      end
      if (advance) begin
         older_row_ff[s1_col_ff] <= mid_rd_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_col_ff      <= col_ff;
         s1_now_ff      <= req_stream.sample_in;
         s1_has_res_ff  <= has_res;
         s1_interior_ff <= interior;
         s1_last_row_ff <= last_row;
         s1_last_col_ff <= last_col;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < MAX_CHANNELS; k++) begin
            win_ff[k] <= '0;
         end
      end else if (advance) begin
         win_ff[0] <= mid_rd_ff;
         for (int k = 1; k < MAX_CHANNELS; k++) begin
            win_ff[k] <= win_ff[k-1];
         end
      end
   end

   always_comb begin
      q_entry.centre   = mid_rd_ff;
      q_entry.above    = old_rd_ff;
      q_entry.below    = s1_now_ff;
      q_entry.left_nb  = win_ff[WIN_IDX_W'(cfg_ch - lss_pkg::CH_W'(1))];
      q_entry.right_nb = east_rd_ff;
      q_entry.interior = s1_interior_ff;
      q_entry.last_row = s1_last_row_ff;
      q_entry.last_col = s1_last_col_ff;
   end

endmodule

// File: rtl/core/lss_queue.sv
// Short word queue between the front end and the result stage.
// Uses lss_pkg for the word type and depth.
module lss_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  lss_pkg::entry_type push_entry,
   output logic               full,
   input  logic               pop,
   output lss_pkg::entry_type pop_entry,
   output logic               not_empty
);

   lss_pkg::entry_type              slot_ff [lss_pkg::QUEUE_DEPTH];
   logic [lss_pkg::QPTR_W-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [lss_pkg::QPTR_W-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [lss_pkg::QCNT_W-1:0]      count_ff, count_in;

   assign full      = count_ff == lss_pkg::QCNT_W'(lss_pkg::QUEUE_DEPTH);
   assign not_empty = count_ff != '0;
   assign pop_entry = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + lss_pkg::QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + lss_pkg::QPTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + lss_pkg::QCNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - lss_pkg::QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset) !(push && full))
      else $error("queue written while full");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset) !(pop && !not_empty))
      else $error("queue read while empty");

endmodule

// File: rtl/core/lss_back.sv
// Result stage: pops classified words, forms 5*centre minus the four
// neighbours with saturation (zero on borders), and adds the border word on the last row.
module lss_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               q_valid,
   input  lss_pkg::entry_type q_entry,
   output logic               q_pop,
   lss_rsp_if.source          rsp_stream
);

   logic                out_valid_ff, out_valid_in;
   lss_pkg::sample_type out_sample_ff, out_sample_in;
   logic                out_last_ff, out_last_in;
   logic                second_ff, second_in;
   logic                second_last_ff, second_last_in;
   logic                load;

   logic [10:0]         centre_x5;
   logic [9:0]          nb_sum;
   logic signed [11:0]  diff;
   lss_pkg::sample_type sharp;

   assign centre_x5 = {1'b0, q_entry.centre, 2'b00} + {3'b000, q_entry.centre};
   assign nb_sum    = {2'b00, q_entry.above} + {2'b00, q_entry.below}
                    + {2'b00, q_entry.left_nb} + {2'b00, q_entry.right_nb};
   assign diff      = $signed({1'b0, centre_x5}) - $signed({2'b00, nb_sum});

   always_comb begin
      // clamp to 0..255; borders give zero
      if (!q_entry.interior || diff < 0) begin
         sharp = '0;
      end else if (diff > 12'sd255) begin
         sharp = '1;
      end else begin
         sharp = diff[lss_pkg::SAMPLE_W-1:0];
      end
   end

   assign load  = !out_valid_ff || rsp_stream.ready;
   assign q_pop = load && !second_ff && q_valid;

   always_comb begin
      out_valid_in   = out_valid_ff;
      out_sample_in  = out_sample_ff;
      out_last_in    = out_last_ff;
      second_in      = second_ff;
      second_last_in = second_last_ff;
      if (load) begin
         if (second_ff) begin
            // the border word owed by a last-row sample
            out_valid_in  = 1'b1;
            out_sample_in = '0;
            out_last_in   = second_last_ff;
            second_in     = 1'b0;
         end else if (q_valid) begin
            out_valid_in   = 1'b1;
            out_sample_in  = sharp;
            out_last_in    = 1'b0;
            second_in      = q_entry.last_row;
            second_last_in = q_entry.last_col;
         end else begin
            out_valid_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         second_ff    <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
         second_ff    <= second_in;
      end
   end

   always_ff @(posedge clock) begin
      out_sample_ff  <= out_sample_in;
      out_last_ff    <= out_last_in;
      second_last_ff <= second_last_in;
   end

   assign rsp_stream.valid      = out_valid_ff;
   assign rsp_stream.sample_out = out_sample_ff;
   assign rsp_stream.frame_last = out_last_ff;

   a_second_follows: assert property (@(posedge clock) disable iff (reset)
      second_ff |-> out_valid_ff)
      else $error("border word owed with no word on the output");
   a_last_is_border: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_last_ff) |-> (out_sample_ff == '0))
      else $error("frame end word is not a border word");

endmodule

// File: tb/tb_laplacian_sharpen_3x3_stream.sv
// Self-checking bench for laplacian_sharpen_3x3_stream: random-gap sample driver,
// stalling result monitor, APB register writes and a built-in line-store predictor.
// Depends on lss_pkg, the lss_req_if/lss_rsp_if interfaces and the block itself.
module tb_laplacian_sharpen_3x3_stream;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int MAX_PIXELS    = 1024;
   localparam int MAX_CHANS     = 4;
   localparam int STORE_DEPTH   = MAX_PIXELS * MAX_CHANS;
   localparam int WINDOW_TAPS   = 9;
   localparam int RANDOM_WORDS  = 200;
   localparam int WIDE_EXTRA    = 8;
   localparam int SETTLE_CYCLES = 8;
   localparam int CYCLE_LIMIT   = 1000000;

   typedef struct {
      lss_pkg::sample_type sample;
      logic                last;
   } sharpened_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                          csr_psel    = 1'b0;
   logic                          csr_penable = 1'b0;
   logic                          csr_pwrite  = 1'b0;
   logic [lss_pkg::PADDR_W-1:0]   csr_paddr   = '0;
   logic [lss_pkg::PDATA_W-1:0]   csr_pwdata  = '0;
   logic [lss_pkg::PDATA_W-1:0]   csr_prdata;
   logic                          csr_pready;

   lss_req_if req_bus ();
   lss_rsp_if rsp_bus ();

   laplacian_sharpen_3x3_stream dut (
      .clock       (clock),
      .reset       (reset),
      .req_stream  (req_bus),
      .rsp_stream  (rsp_bus),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // predictor state
   logic [lss_pkg::CFG_WIDTH_W-1:0] width_reg  = lss_pkg::RESET_IMAGE_WIDTH;
   logic [lss_pkg::ROW_W-1:0]       height_reg = lss_pkg::RESET_IMAGE_HEIGHT;
   logic [lss_pkg::CH_W-1:0]        chan_reg   = lss_pkg::RESET_CHANNEL_COUNT;
   lss_pkg::sample_type             older_row   [STORE_DEPTH];
   lss_pkg::sample_type             middle_row  [STORE_DEPTH];
   lss_pkg::sample_type             middle_taps [WINDOW_TAPS];
   int unsigned                     sample_col = 0;
   int unsigned                     row_idx    = 0;

   sharpened_type       sharpened_due [$];
   lss_pkg::sample_type pending_samples [$];
   int unsigned         queued_count   = 0;
   int unsigned         accepted_count = 0;
   int unsigned         mismatch_count = 0;
   int unsigned         cycle_count    = 0;

   function automatic int unsigned eff_width();
      if (width_reg < 3) return 3;
      if (width_reg > MAX_PIXELS) return MAX_PIXELS;
      return 32'(width_reg);
   endfunction

   function automatic int unsigned eff_chans();
      if (chan_reg == 0) return 1;
      if (chan_reg > MAX_CHANS) return MAX_CHANS;
      return 32'(chan_reg);
   endfunction

   function automatic int unsigned eff_height();
      return (height_reg < 3) ? 3 : 32'(height_reg);
   endfunction

   function automatic int unsigned frame_len();
      return eff_width() * eff_chans() * eff_height();
   endfunction

   function automatic void predict_sharpen(input lss_pkg::sample_type now);
      int unsigned         w, ch, len, c;
      lss_pkg::sample_type mid, old, left, right;
      int                  sum;
      logic                last_row, last_col, interior;
      sharpened_type       word;
      w        = eff_width();
      ch       = eff_chans();
      len      = w * ch;
      c        = sample_col;
      mid      = middle_row[c];
      old      = older_row[c];
      left     = middle_taps[ch - 1];
      right    = (c + ch < STORE_DEPTH) ? middle_row[c + ch] : '0;
      last_row = (row_idx + 1 >= eff_height());
      last_col = (c + 1 >= len);
      if (row_idx >= 1) begin
         interior = (row_idx >= 2) && (c >= ch) && (c < (w - 1) * ch);
         word.sample = '0;
         word.last   = 1'b0;
         if (interior) begin
            sum = 5 * int'(mid) - int'(left) - int'(right) - int'(old) - int'(now);
            if (sum < 0) sum = 0;
            if (sum > 255) sum = 255;
            word.sample = lss_pkg::sample_type'(sum);
         end
         sharpened_due.push_back(word);
         // last row also closes the bottom border row
         if (last_row) begin
            word.sample = '0;
            word.last   = last_col;
            sharpened_due.push_back(word);
         end
      end
      for (int k = WINDOW_TAPS - 1; k > 0; k--)
         middle_taps[k] = middle_taps[k - 1];
      middle_taps[0] = mid;
      older_row[c]   = mid;
      middle_row[c]  = now;
      if (last_col) begin
         sample_col = 0;
         row_idx    = last_row ? 0 : row_idx + 1;
      end else begin
         sample_col = c + 1;
      end
   endfunction

   // sample driver: bursts of random length with random gaps
   int unsigned burst_left = 1;
   int unsigned gap_left   = 0;

   always @(posedge clock) begin : req_driver
      logic                next_valid;
      lss_pkg::sample_type next_sample;
      if (reset) begin
         req_bus.valid     <= 1'b0;
         req_bus.sample_in <= '0;
      end else begin
         next_valid  = req_bus.valid;
         next_sample = req_bus.sample_in;
         if (req_bus.valid && req_bus.ready) begin
            predict_sharpen(req_bus.sample_in);
            accepted_count++;
            next_valid = 1'b0;
         end
         if (!next_valid) begin
            if (gap_left > 0) begin
               gap_left--;
            end else if (pending_samples.size() > 0) begin
               next_sample = pending_samples.pop_front();
               next_valid  = 1'b1;
               burst_left--;
               if (burst_left == 0) begin
                  burst_left = ($urandom_range(0, 7) == 0) ? 200 : $urandom_range(1, 24);
                  gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
               end
            end
         end
         req_bus.valid     <= next_valid;
         req_bus.sample_in <= next_sample;
      end
   end

   // result monitor with its own rotating stall pattern
   logic [31:0] stall_pattern = '1;
   logic [4:0]  stall_phase   = '0;

   always @(posedge clock) begin : rsp_monitor
      sharpened_type due;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (sharpened_due.size() == 0) begin
               if (mismatch_count < 10)
                  $display("unexpected word: sample %0d last %0b",
                           rsp_bus.sample_out, rsp_bus.frame_last);
               mismatch_count++;
            end else begin
               due = sharpened_due.pop_front();
               if (rsp_bus.sample_out !== due.sample || rsp_bus.frame_last !== due.last) begin
                  if (mismatch_count < 10)
                     $display("mismatch: expected sample %0d last %0b, got sample %0d last %0b",
                              due.sample, due.last, rsp_bus.sample_out, rsp_bus.frame_last);
                  mismatch_count++;
               end
            end
         end
         if (stall_phase == 0) begin
            case ($urandom_range(0, 3))
               0: stall_pattern = '1;
               1: stall_pattern = $urandom;
               2: stall_pattern = 32'hAAAA_AAAA;
               default: stall_pattern = $urandom | $urandom;
            endcase
         end
         rsp_bus.ready <= stall_pattern[stall_phase];
         stall_phase = stall_phase + 5'd1;
      end
   end

   always @(posedge clock) begin : watchdog
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("laplacian_sharpen_3x3_stream test failed");
         $finish;
      end
   end

   task automatic write_register(input lss_pkg::reg_idx_type idx,
                                 input logic [lss_pkg::PDATA_W-1:0] value);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= lss_pkg::PADDR_W'({idx, 2'b00});
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      case (idx)
         lss_pkg::REG_IMAGE_WIDTH:   width_reg  = value[lss_pkg::CFG_WIDTH_W-1:0];
         lss_pkg::REG_IMAGE_HEIGHT:  height_reg = value[lss_pkg::ROW_W-1:0];
         lss_pkg::REG_CHANNEL_COUNT: chan_reg   = value[lss_pkg::CH_W-1:0];
         default: ;
      endcase
      sample_col = 0;
      row_idx    = 0;
   endtask

   // upper bits of pwdata carry junk now and then; only the field bits count
   task automatic set_geometry(input logic [lss_pkg::CFG_WIDTH_W-1:0] w,
                               input logic [lss_pkg::ROW_W-1:0] h,
                               input logic [lss_pkg::CH_W-1:0] ch);
      logic [lss_pkg::PDATA_W-1:0] noise;
      noise = ($urandom_range(0, 3) == 0) ? $urandom : '0;
      write_register(lss_pkg::REG_IMAGE_WIDTH,
                     {noise[lss_pkg::PDATA_W-1:lss_pkg::CFG_WIDTH_W], w});
      noise = ($urandom_range(0, 3) == 0) ? $urandom : '0;
      write_register(lss_pkg::REG_IMAGE_HEIGHT,
                     {noise[lss_pkg::PDATA_W-1:lss_pkg::ROW_W], h});
      noise = ($urandom_range(0, 3) == 0) ? $urandom : '0;
      write_register(lss_pkg::REG_CHANNEL_COUNT,
                     {noise[lss_pkg::PDATA_W-1:lss_pkg::CH_W], ch});
   endtask

   task automatic queue_word(input lss_pkg::sample_type s);
      pending_samples.push_back(s);
      queued_count++;
   endtask

   task automatic queue_words(input int unsigned count, input int unsigned style);
      lss_pkg::sample_type s;
      for (int unsigned i = 0; i < count; i++) begin
         case (style)
            0: s = lss_pkg::sample_type'($urandom_range(0, 255));
            1: s = $urandom_range(0, 1) ? 8'd255 : 8'd0;
            2: s = 8'd100 + lss_pkg::sample_type'($urandom_range(0, 40));
            default: s = ($urandom_range(0, 9) == 0) ? 8'd255
                         : lss_pkg::sample_type'($urandom_range(0, 30));
         endcase
         queue_word(s);
      end
   endtask

   // hold until every word is accepted and answered, then let the pipe empty
   task automatic wait_drained();
      while (accepted_count != queued_count || sharpened_due.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   initial begin
      int unsigned random_words;
      int unsigned frames;
      int unsigned count;
      logic [lss_pkg::CFG_WIDTH_W-1:0] w;
      logic [lss_pkg::ROW_W-1:0]       h;
      logic [lss_pkg::CH_W-1:0]        ch;
      random_words = 0;
      req_bus.valid     = 1'b0;
      req_bus.sample_in = '0;
      rsp_bus.ready     = 1'b0;
      for (int i = 0; i < STORE_DEPTH; i++) begin
         older_row[i]  = '0;
         middle_row[i] = '0;
      end
      for (int i = 0; i < WINDOW_TAPS; i++)
         middle_taps[i] = '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // lone bright centre saturates high, lone dark centre saturates low,
      // back to back so the frame wraps
      set_geometry(11'd3, 16'd3, 3'd1);
      for (int i = 0; i < 9; i++)
         queue_word((i == 4) ? 8'd255 : 8'd0);
      for (int i = 0; i < 9; i++)
         queue_word((i == 4) ? 8'd0 : 8'd255);
      wait_drained();

      // oversize width and zero height and channel count clamp;
      // stop just after the widest row wraps
      set_geometry(11'd2047, 16'd0, 3'd0);
      queue_words(MAX_PIXELS + WIDE_EXTRA, 1);
      wait_drained();

      // stop part-way down a tall frame; the next write must restart the position
      set_geometry(11'd0, 16'd65535, 3'd5);
      queue_words(60, 0);
      wait_drained();

      while (random_words < RANDOM_WORDS) begin
         w  = lss_pkg::CFG_WIDTH_W'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 2)
                                                               : $urandom_range(3, 12));
         h  = lss_pkg::ROW_W'(($urandom_range(0, 7) == 0) ? $urandom_range(0, 2)
                                                         : $urandom_range(3, 6));
         ch = lss_pkg::CH_W'($urandom_range(0, 7));
         set_geometry(w, h, ch);
         frames = $urandom_range(1, 3);
         for (int unsigned f = 0; f < frames; f++) begin
            count = frame_len();
            if (f == frames - 1 && $urandom_range(0, 5) == 0)
               count = $urandom_range(1, count - 1);
            queue_words(count, $urandom_range(0, 3));
            random_words += count;
         end
         wait_drained();
      end

      if (mismatch_count == 0)
         $display("laplacian_sharpen_3x3_stream test passed");
      else
         $display("laplacian_sharpen_3x3_stream test failed");
      $finish;
   end

endmodule
